// ----- src/sfcd_pkg.sv -----
package sfcd_pkg;

	localparam int BYTE_W = 8;
	localparam int WORD_W = 16;
	localparam int CENTI_W = 15;
	localparam int PROD_W = WORD_W + CENTI_W;

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
	localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

	localparam logic [CENTI_W-1:0] TEMP_SPAN = 15'd17500;
	localparam logic [CENTI_W-1:0] HUM_SPAN = 15'd12500;
	localparam logic signed [CENTI_W-1:0] TEMP_OFFSET = -15'sd4500;
	localparam logic signed [CENTI_W-1:0] HUM_OFFSET = -15'sd600;
	localparam logic [WORD_W:0] FULL_SCALE = 17'd65535;

	typedef enum logic [2:0] {
		POS_TEMP_HI  = 3'd0,
		POS_TEMP_LO  = 3'd1,
		POS_TEMP_CRC = 3'd2,
		POS_HUM_HI   = 3'd3,
		POS_HUM_LO   = 3'd4,
		POS_HUM_CRC  = 3'd5
	} pos_t;

	typedef logic signed [CENTI_W-1:0] centi_t;

	function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0] c;
		c = crc ^ data;
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

	// The product is split as a*65536 + b = a*65535 + (a + b); since a + b stays
	// below twice the full scale, one compare finishes the division by 65535.
	function automatic centi_t scale_centi(input logic [PROD_W-1:0] prod,
		input centi_t offset);
		logic [CENTI_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W:0] sum;
		logic [CENTI_W-1:0] q;
		a = prod[PROD_W-1:WORD_W];
		b = prod[WORD_W-1:0];
		sum = {2'b00, a} + {1'b0, b};
		q = a + CENTI_W'(sum >= FULL_SCALE);
		return centi_t'(q + offset);
	endfunction

endpackage

// ----- src/sfcd_if.sv -----
interface sfcd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source (output valid, rx_byte, frame_start, input ready);
	modport sink (input valid, rx_byte, frame_start, output ready);
endinterface

interface sfcd_out_if;
	logic               valid;
	logic               ready;
	logic signed [14:0] temperature_centi;
	logic signed [14:0] humidity_centi;
	logic               temp_crc_ok;
	logic               hum_crc_ok;
	logic               frame_ok;

	modport source (output valid, temperature_centi, humidity_centi, temp_crc_ok,
		hum_crc_ok, frame_ok, input ready);
	modport sink (input valid, temperature_centi, humidity_centi, temp_crc_ok,
		hum_crc_ok, frame_ok, output ready);
endinterface

// ----- src/sensor_frame_crc_decode.sv -----
// Decodes the six-byte temperature/humidity reply, one byte per beat: temperature
// high, low, CRC-8, then humidity high, low, CRC-8 (polynomial 0x31, init 0xFF).
// A beat with frame_start set restarts the frame at its first byte and drops any
// partial frame. The sixth byte yields one result beat with the scaled readings in
// hundredths (unclamped) and the two CRC flags. A byte is taken every cycle while
// the result side keeps up; a result is registered first in the scaling multiplier
// stage and then in the output register.
module sensor_frame_crc_decode (
	input logic        clk,
	input logic        arst_n,
	sfcd_in_if.sink    rx,
	sfcd_out_if.source res
);
	import sfcd_pkg::*;

	pos_t              pos_q;
	pos_t              pos_cur;
	pos_t              pos_nxt;
	logic [BYTE_W-1:0] crc_q;
	logic [BYTE_W-1:0] crc_base;
	logic [BYTE_W-1:0] crc_calc;
	logic [BYTE_W-1:0] hold_q;
	logic [WORD_W-1:0] temp_word_q;
	logic [WORD_W-1:0] hum_word_q;
	logic              temp_good_q;
	logic              advance;
	logic              rx_fire;
	logic              last_byte;

	logic              valid_s1;
	logic [PROD_W-1:0] temp_prod_s1;
	logic [PROD_W-1:0] hum_prod_s1;
	logic              temp_ok_s1;
	logic              hum_ok_s1;

	logic              out_valid_q;
	centi_t            temp_centi_q;
	centi_t            hum_centi_q;
	logic              temp_ok_q;
	logic              hum_ok_q;
	logic              frame_ok_q;

	assign advance = !out_valid_q || res.ready;
	assign rx.ready = advance;
	assign rx_fire = rx.valid && advance;

	always_comb begin
		if (rx.frame_start || pos_q > POS_HUM_CRC) begin
			pos_cur = POS_TEMP_HI;
		end else begin
			pos_cur = pos_q;
		end
		if (pos_cur == POS_TEMP_HI || pos_cur == POS_HUM_HI) begin
			crc_base = CRC_INIT;
		end else begin
			crc_base = crc_q;
		end
		crc_calc = crc8_feed(crc_base, rx.rx_byte);
		last_byte = pos_cur == POS_HUM_CRC;
	end

	always_comb begin
		unique case (pos_cur)
			POS_TEMP_HI:  pos_nxt = POS_TEMP_LO;
			POS_TEMP_LO:  pos_nxt = POS_TEMP_CRC;
			POS_TEMP_CRC: pos_nxt = POS_HUM_HI;
			POS_HUM_HI:   pos_nxt = POS_HUM_LO;
			POS_HUM_LO:   pos_nxt = POS_HUM_CRC;
			default:      pos_nxt = POS_TEMP_HI;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_TEMP_HI;
			crc_q <= CRC_INIT;
		end else if (rx_fire) begin
			pos_q <= pos_nxt;
			if (pos_cur == POS_TEMP_CRC || pos_cur == POS_HUM_CRC) begin
				crc_q <= CRC_INIT;
			end else begin
				crc_q <= crc_calc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_fire) begin
			case (pos_cur) inside
				POS_TEMP_HI, POS_HUM_HI: hold_q <= rx.rx_byte;
				POS_TEMP_LO:             temp_word_q <= {hold_q, rx.rx_byte};
				POS_TEMP_CRC:            temp_good_q <= rx.rx_byte == crc_q;
				POS_HUM_LO:              hum_word_q <= {hold_q, rx.rx_byte};
				default:                 ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1 <= rx_fire && last_byte;
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_fire && last_byte) begin
			temp_prod_s1 <= {{WORD_W{1'b0}}, TEMP_SPAN} * {{CENTI_W{1'b0}}, temp_word_q};
			hum_prod_s1 <= {{WORD_W{1'b0}}, HUM_SPAN} * {{CENTI_W{1'b0}}, hum_word_q};
			temp_ok_s1 <= temp_good_q;
			hum_ok_s1 <= rx.rx_byte == crc_q;
		end
		if (advance && valid_s1) begin
			temp_centi_q <= scale_centi(temp_prod_s1, TEMP_OFFSET);
			hum_centi_q <= scale_centi(hum_prod_s1, HUM_OFFSET);
			temp_ok_q <= temp_ok_s1;
			hum_ok_q <= hum_ok_s1;
			frame_ok_q <= temp_ok_s1 && hum_ok_s1;
		end
	end

	assign res.valid = out_valid_q;
	assign res.temperature_centi = temp_centi_q;
	assign res.humidity_centi = hum_centi_q;
	assign res.temp_crc_ok = temp_ok_q;
	assign res.hum_crc_ok = hum_ok_q;
	assign res.frame_ok = frame_ok_q;

	a_pos_reachable: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_HUM_CRC)
		else $error("byte position left the frame");

	a_start_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		rx_fire && rx.frame_start |=> pos_q == POS_TEMP_LO)
		else $error("frame start did not restart the frame");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(temp_prod_s1))
		else $error("scaling stage lost a result under stall");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result beat without a completed frame");

	a_frame_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> frame_ok_q == (temp_ok_q && hum_ok_q))
		else $error("frame_ok disagrees with the CRC flags");

endmodule

// ----- sim/sfcd_frame_checker.sv -----
package sfcd_tb_pkg;

	import sfcd_pkg::*;

	// One CRC-8 byte update, polynomial 0x31, most significant bit first.
	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		repeat (8) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

endpackage

module sfcd_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_start,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [14:0] temperature_centi,
	input  logic [14:0] humidity_centi,
	input  logic        temp_crc_ok,
	input  logic        hum_crc_ok,
	input  logic        frame_ok,
	output int          mismatches,
	output int          outstanding,
	output int          frames_done,
	output int          frames_failed,
	output int          restarts
);

	import sfcd_pkg::*;
	import sfcd_tb_pkg::*;

	typedef struct packed {
		centi_t temp;
		centi_t hum;
		logic   temp_ok;
		logic   hum_ok;
		logic   both_ok;
	} reading_t;

	reading_t pending_readings[$];

	pos_t        next_pos;
	logic [7:0]  word_crc;
	logic [7:0]  hi_hold;
	logic [15:0] temp_word;
	logic [15:0] hum_word;
	logic        temp_good;

	function automatic centi_t to_centi(input logic [15:0] raw, input int span,
		input int offset);
		longint q;
		centi_t r;
		q = (longint'(span) * longint'(raw)) / 65535;
		r = centi_t'(longint'(offset) + q);
		return r;
	endfunction

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10) begin
			$display("Mismatch at %0t: %s", $time, what);
		end
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic start);
		pos_t     p;
		reading_t r;
		logic     hum_good;
		p = next_pos;
		if (start) begin
			if (next_pos != POS_TEMP_HI) begin
				restarts++;
			end
			p = POS_TEMP_HI;
			word_crc = CRC_INIT;
		end
		if (p > POS_HUM_CRC) begin
			p = POS_TEMP_HI;
		end
		case (p)
			POS_TEMP_HI, POS_HUM_HI: begin
				word_crc = crc_step(CRC_INIT, b);
				hi_hold = b;
				next_pos = pos_t'(p + 3'd1);
			end
			POS_TEMP_LO: begin
				word_crc = crc_step(word_crc, b);
				temp_word = {hi_hold, b};
				next_pos = POS_TEMP_CRC;
			end
			POS_HUM_LO: begin
				word_crc = crc_step(word_crc, b);
				hum_word = {hi_hold, b};
				next_pos = POS_HUM_CRC;
			end
			POS_TEMP_CRC: begin
				temp_good = (b == word_crc);
				word_crc = CRC_INIT;
				next_pos = POS_HUM_HI;
			end
			default: begin
				hum_good = (b == word_crc);
				word_crc = CRC_INIT;
				next_pos = POS_TEMP_HI;
				r.temp = to_centi(temp_word, 17500, -4500);
				r.hum = to_centi(hum_word, 12500, -600);
				r.temp_ok = temp_good;
				r.hum_ok = hum_good;
				r.both_ok = temp_good & hum_good;
				pending_readings.push_back(r);
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		reading_t e;
		if (!arst_n) begin
			pending_readings.delete();
			next_pos = POS_TEMP_HI;
			word_crc = CRC_INIT;
			hi_hold = '0;
			temp_word = '0;
			hum_word = '0;
			temp_good = 1'b0;
			mismatches = 0;
			outstanding = 0;
			frames_done = 0;
			frames_failed = 0;
			restarts = 0;
		end else begin
			if (in_valid && in_ready) begin
				decode_byte(in_byte, in_start);
			end
			if (out_valid && out_ready) begin
				if (pending_readings.size() == 0) begin
					flag_mismatch("result beat with no frame pending");
				end else begin
					e = pending_readings.pop_front();
					frames_done++;
					if (!e.both_ok) begin
						frames_failed++;
					end
					if (temperature_centi !== e.temp || humidity_centi !== e.hum
						|| temp_crc_ok !== e.temp_ok || hum_crc_ok !== e.hum_ok
						|| frame_ok !== e.both_ok) begin
						flag_mismatch($sformatf({"expected temp %0d hum %0d flags %b%b%b, ",
							"got temp %0d hum %0d flags %b%b%b"},
							e.temp, e.hum, e.temp_ok, e.hum_ok, e.both_ok,
							$signed(temperature_centi), $signed(humidity_centi),
							temp_crc_ok, hum_crc_ok, frame_ok));
					end
				end
			end
			outstanding = pending_readings.size();
		end
	end

endmodule

// ----- sim/sensor_frame_crc_decode_tb.sv -----
module sensor_frame_crc_decode_tb;

	import sfcd_pkg::*;
	import sfcd_tb_pkg::*;

	logic clk;
	logic arst_n;

	sfcd_in_if  rx ();
	sfcd_out_if res ();

	int mismatches;
	int outstanding;
	int frames_done;
	int frames_failed;
	int restarts;
	int bytes_sent;
	bit idle_on;
	bit drained_mid;

	sensor_frame_crc_decode dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.res    (res)
	);

	sfcd_frame_checker chk (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (rx.valid),
		.in_ready          (rx.ready),
		.in_byte           (rx.rx_byte),
		.in_start          (rx.frame_start),
		.out_valid         (res.valid),
		.out_ready         (res.ready),
		.temperature_centi (res.temperature_centi),
		.humidity_centi    (res.humidity_centi),
		.temp_crc_ok       (res.temp_crc_ok),
		.hum_crc_ok        (res.hum_crc_ok),
		.frame_ok          (res.frame_ok),
		.mismatches        (mismatches),
		.outstanding       (outstanding),
		.frames_done       (frames_done),
		.frames_failed     (frames_failed),
		.restarts          (restarts)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("TB_ERROR");
		$finish;
	end

	// The result side stalls in random bursts while idling is enabled.
	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				res.ready = 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
			res.ready = 1'b1;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fs);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			rx.valid = 1'b0;
			rx.rx_byte = 8'($urandom);
			rx.frame_start = 1'($urandom);
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		rx.valid = 1'b1;
		rx.rx_byte = b;
		rx.frame_start = fs;
		@(posedge clk);
		while (!rx.ready) @(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
		input bit bad_t, input bit bad_h, input logic fs, input int n_bytes);
		logic [7:0] beats [6];
		beats[0] = t_raw[15:8];
		beats[1] = t_raw[7:0];
		beats[2] = crc_step(crc_step(CRC_INIT, t_raw[15:8]), t_raw[7:0]);
		beats[3] = h_raw[15:8];
		beats[4] = h_raw[7:0];
		beats[5] = crc_step(crc_step(CRC_INIT, h_raw[15:8]), h_raw[7:0]);
		if (bad_t) begin
			beats[2] ^= 8'($urandom_range(1, 255));
		end
		if (bad_h) begin
			beats[5] ^= 8'($urandom_range(1, 255));
		end
		for (int i = 0; i < n_bytes; i++) begin
			send_byte(beats[i], (i == 0) ? fs : 1'b0);
		end
	endtask

	task automatic wait_for_results();
		rx.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		rx.valid = 1'b0;
		rx.rx_byte = '0;
		rx.frame_start = 1'b0;
		arst_n = 1'b0;
		bytes_sent = 0;
		idle_on = 1'b1;
		drained_mid = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed frames: scale extremes, self-wrapping frame without a start flag,
		// each CRC failure, and a partial frame dropped by a restart.
		send_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 6);
		send_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 6);
		send_frame(16'h8000, 16'h1234, 1'b1, 1'b0, 1'b1, 6);
		send_frame(16'hA5C3, 16'h5A3C, 1'b0, 1'b0, 1'b1, 2);
		send_frame(16'h7FFF, 16'hBEEF, 1'b0, 1'b1, 1'b1, 6);
		wait_for_results();

		while (bytes_sent < 640) begin
			idle_on = (bytes_sent % 128) < 96 && bytes_sent < 540;
			case ($urandom_range(0, 9))
				0: begin
					repeat ($urandom_range(1, 4)) begin
						send_byte(8'($urandom), $urandom_range(0, 3) == 0);
					end
				end
				1: send_frame(pick_word(), pick_word(), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'b1, int'($urandom_range(1, 5)));
				default: send_frame(pick_word(), pick_word(), $urandom_range(0, 5) == 0,
					$urandom_range(0, 5) == 0, $urandom_range(0, 3) != 0, 6);
			endcase
			if (!drained_mid && bytes_sent >= 300) begin
				drained_mid = 1'b1;
				wait_for_results();
			end
		end

		wait_for_results();
		repeat (10) @(negedge clk);
		$display("Sent %0d bytes; %0d frames decoded, %0d of them with a CRC error.",
			bytes_sent, frames_done, frames_failed);
		$display("Partial frames dropped by a restart: %0d.", restarts);
		if (mismatches == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
